// File: hw/rtl/tbo_pkg.sv
// shared constants, widths and types for the triangle/box overlap test
package tbo_pkg;

   localparam int COORD_BITS = 32;
   localparam int HALF_W     = 31;
   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(32768);

   // relative vertices and edges
   localparam int V_W = COORD_BITS + 1;
   localparam int E_W = COORD_BITS + 2;

   // edge cross box axis
   localparam int EP_W = V_W + E_W;
   localparam int ED_W = EP_W + 1;
   localparam int ER_W = HALF_W + E_W + 1;
   localparam int EC_W = ED_W + 1;

   // triangle normal
   localparam int NP_W  = 2 * E_W;
   localparam int N_W   = NP_W + 1;
   localparam int NLO_W = N_W - E_W;
   localparam int NHI_W = E_W;
   localparam int PL_W  = V_W + NLO_W + 1;
   localparam int PH_W  = V_W + NHI_W;
   localparam int P_W   = V_W + N_W + 2;
   localparam int RL_W  = HALF_W + NLO_W;
   localparam int RH_W  = HALF_W + NHI_W;
   localparam int R_W   = HALF_W + N_W + 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_X = 2'd0,
      CSR_HALF_Y = 2'd1,
      CSR_HALF_Z = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic signed [E_W-1:0]  ea;
      logic signed [E_W-1:0]  eb;
      logic [E_W-1:0]         aea;
      logic [E_W-1:0]         aeb;
      logic signed [V_W-1:0]  va;
      logic signed [V_W-1:0]  vb;
      logic signed [V_W-1:0]  wa;
      logic signed [V_W-1:0]  wb;
      logic [HALF_W-1:0]      ha;
      logic [HALF_W-1:0]      hb;
   } edge_opnd_type;

endpackage

// File: hw/rtl/tbo_req_if.sv
// request channel carrying box center and triangle vertices
interface tbo_req_if;
   logic valid;
   logic ready;
   logic signed [tbo_pkg::COORD_BITS-1:0] center_x;
   logic signed [tbo_pkg::COORD_BITS-1:0] center_y;
   logic signed [tbo_pkg::COORD_BITS-1:0] center_z;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert0_x;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert0_y;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert0_z;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert1_x;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert1_y;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert1_z;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert2_x;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert2_y;
   logic signed [tbo_pkg::COORD_BITS-1:0] vert2_z;

   modport source (output valid, center_x, center_y, center_z, vert0_x, vert0_y, vert0_z,
                   vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, input ready);
   modport sink (input valid, center_x, center_y, center_z, vert0_x, vert0_y, vert0_z,
                 vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

// File: hw/rtl/tbo_rsp_if.sv
// response channel carrying the overlap flag
interface tbo_rsp_if;
   logic valid;
   logic ready;
   logic overlaps;

   modport source (output valid, overlaps, input ready);
   modport sink (input valid, overlaps, output ready);
endinterface

// File: hw/rtl/tbo_csr_if.sv
// configuration write channel
interface tbo_csr_if;
   logic valid;
   logic ready;
   logic [tbo_pkg::CSR_IDX_W-1:0]  index;
   logic [tbo_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tbo_edge_axis.sv
// three stage test of one edge cross box axis
module tbo_edge_axis (
   input  logic                   clock,
   input  logic                   en,
   input  tbo_pkg::edge_opnd_type opnd,
   output logic                   sep
);

   logic signed [tbo_pkg::EP_W-1:0] pv1_in, pv2_in, pw1_in, pw2_in;
   logic signed [tbo_pkg::EP_W-1:0] pv1_ff, pv2_ff, pw1_ff, pw2_ff;
   logic [tbo_pkg::HALF_W+tbo_pkg::E_W-1:0] r1_in, r2_in, r1_ff, r2_ff;
   logic signed [tbo_pkg::ED_W-1:0] pa_in, pc_in, pa_ff, pc_ff;
   logic [tbo_pkg::ER_W-1:0] rad_in, rad_ff;
   logic signed [tbo_pkg::EC_W-1:0] prad, nrad;
   logic sep_in, sep_ff;

   // projections and radius terms
   assign pv1_in = $signed(opnd.va) * $signed(opnd.eb);
   assign pv2_in = $signed(opnd.vb) * $signed(opnd.ea);
   assign pw1_in = $signed(opnd.wa) * $signed(opnd.eb);
   assign pw2_in = $signed(opnd.wb) * $signed(opnd.ea);
   assign r1_in  = opnd.ha * opnd.aeb;
   assign r2_in  = opnd.hb * opnd.aea;

   assign pa_in  = pv1_ff - pv2_ff;
   assign pc_in  = pw1_ff - pw2_ff;
   assign rad_in = tbo_pkg::ER_W'(r1_ff) + tbo_pkg::ER_W'(r2_ff);

   assign prad   = $signed({1'b0, rad_ff});
   assign nrad   = -prad;
   assign sep_in = (pa_ff > prad && pc_ff > prad) || (pa_ff < nrad && pc_ff < nrad);

   always_ff @(posedge clock) begin
      if (en) begin
         pv1_ff <= pv1_in;
         pv2_ff <= pv2_in;
         pw1_ff <= pw1_in;
         pw2_ff <= pw2_in;
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         pa_ff  <= pa_in;
         pc_ff  <= pc_in;
         rad_ff <= rad_in;
         sep_ff <= sep_in;
      end
   end

   assign sep = sep_ff;

endmodule

// File: hw/rtl/triangle_box_overlap_test.sv
// triangle versus axis-aligned box overlap test, separating axis pipeline
// throughput: one request per cycle; a stalled response freezes the whole pipeline
// req ready is low only while a finished response waits and rsp ready is low
// reset clears all valid bits and sets the half extents to 0.5 (Q15.16)
module triangle_box_overlap_test (
   input  logic          clock,
   input  logic          reset,
   tbo_req_if.sink       req_bus,
   tbo_rsp_if.source     rsp_bus,
   tbo_csr_if.sink       csr_bus
);

   localparam int NSTG = 9;

   logic [NSTG:1] vld_ff, vld_in;
   logic en;
   logic [tbo_pkg::HALF_W-1:0] half_ff [3];

   logic signed [tbo_pkg::COORD_BITS-1:0] cen [3];
   logic signed [tbo_pkg::COORD_BITS-1:0] vrt [3][3];

   logic signed [tbo_pkg::V_W-1:0] v1_in [3][3];
   logic signed [tbo_pkg::V_W-1:0] v1_ff [3][3], v2_ff [3][3], v3_ff [3][3];
   logic signed [tbo_pkg::V_W-1:0] v0_ff [4:6][3];
   logic signed [tbo_pkg::E_W-1:0] e2_in [3][3], e2_ff [3][3], e3_ff [3][3];
   logic [tbo_pkg::E_W-1:0] ae3_in [3][3], ae3_ff [3][3];
   logic box_in;
   logic box_ff [2:6];
   logic signed [tbo_pkg::NP_W-1:0] np_in [3][2], np_ff [3][2];
   logic signed [tbo_pkg::N_W-1:0] n_in [3], n5_ff [3], n6_ff [3];
   logic [tbo_pkg::N_W-1:0] an_in [3], an_ff [3];
   logic [8:0] edge_sep;
   logic sep7_in, sep7_ff, sep8_ff;
   logic signed [tbo_pkg::PL_W-1:0] pl_in [3], pl_ff [3];
   logic signed [tbo_pkg::PH_W-1:0] ph_in [3], ph_ff [3];
   logic [tbo_pkg::RL_W-1:0] rl_in [3], rl_ff [3];
   logic [tbo_pkg::RH_W-1:0] rh_in [3], rh_ff [3];
   logic signed [tbo_pkg::P_W-1:0] p_in, p_ff, prad, nrad;
   logic [tbo_pkg::R_W-1:0] r_in, r_ff;
   logic ovl_in, ovl_ff;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff[0] <= tbo_pkg::HALF_RESET;
         half_ff[1] <= tbo_pkg::HALF_RESET;
         half_ff[2] <= tbo_pkg::HALF_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tbo_pkg::CSR_HALF_X: half_ff[0] <= csr_bus.data[tbo_pkg::HALF_W-1:0];
            tbo_pkg::CSR_HALF_Y: half_ff[1] <= csr_bus.data[tbo_pkg::HALF_W-1:0];
            tbo_pkg::CSR_HALF_Z: half_ff[2] <= csr_bus.data[tbo_pkg::HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   assign en            = ~vld_ff[NSTG] | rsp_bus.ready;
   assign req_bus.ready = en;
   assign vld_in        = {vld_ff[NSTG-1:1], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign cen[0]    = req_bus.center_x;
   assign cen[1]    = req_bus.center_y;
   assign cen[2]    = req_bus.center_z;
   assign vrt[0][0] = req_bus.vert0_x;
   assign vrt[0][1] = req_bus.vert0_y;
   assign vrt[0][2] = req_bus.vert0_z;
   assign vrt[1][0] = req_bus.vert1_x;
   assign vrt[1][1] = req_bus.vert1_y;
   assign vrt[1][2] = req_bus.vert1_z;
   assign vrt[2][0] = req_bus.vert2_x;
   assign vrt[2][1] = req_bus.vert2_y;
   assign vrt[2][2] = req_bus.vert2_z;

   // stage 1: vertices relative to center; stage 2: edges and box axes
   always_comb begin
      logic signed [tbo_pkg::V_W-1:0] h, nh;
      logic all_hi, all_lo;
      box_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            v1_in[i][k] = tbo_pkg::V_W'(vrt[i][k]) - tbo_pkg::V_W'(cen[k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         e2_in[0][k] = tbo_pkg::E_W'(v1_ff[1][k]) - tbo_pkg::E_W'(v1_ff[0][k]);
         e2_in[1][k] = tbo_pkg::E_W'(v1_ff[2][k]) - tbo_pkg::E_W'(v1_ff[1][k]);
         e2_in[2][k] = tbo_pkg::E_W'(v1_ff[0][k]) - tbo_pkg::E_W'(v1_ff[2][k]);
         h      = $signed({2'b00, half_ff[k]});
         nh     = -h;
         all_hi = 1'b1;
         all_lo = 1'b1;
         for (int i = 0; i < 3; i++) begin
            all_hi = all_hi & (v1_ff[i][k] > h);
            all_lo = all_lo & (v1_ff[i][k] < nh);
         end
         box_in = box_in | all_hi | all_lo;
      end
   end

   // stage 3: edge magnitudes; stage 4: normal products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            ae3_in[i][k] = e2_ff[i][k][tbo_pkg::E_W-1] ? tbo_pkg::E_W'(-e2_ff[i][k])
                                                         : tbo_pkg::E_W'(e2_ff[i][k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         np_in[k][0] = e3_ff[0][(k+1)%3] * e3_ff[1][(k+2)%3];
         np_in[k][1] = e3_ff[0][(k+2)%3] * e3_ff[1][(k+1)%3];
      end
   end

   // stage 5: normal; stage 6: its magnitude; stage 7: split products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_in[k]  = tbo_pkg::N_W'(np_ff[k][0]) - tbo_pkg::N_W'(np_ff[k][1]);
         an_in[k] = n5_ff[k][tbo_pkg::N_W-1] ? tbo_pkg::N_W'(-n5_ff[k])
                                              : tbo_pkg::N_W'(n5_ff[k]);
         pl_in[k] = v0_ff[6][k] * $signed({1'b0, n6_ff[k][tbo_pkg::NLO_W-1:0]});
         ph_in[k] = v0_ff[6][k] * $signed(n6_ff[k][tbo_pkg::N_W-1:tbo_pkg::NLO_W]);
         rl_in[k] = half_ff[k] * an_ff[k][tbo_pkg::NLO_W-1:0];
         rh_in[k] = half_ff[k] * an_ff[k][tbo_pkg::N_W-1:tbo_pkg::NLO_W];
      end
   end

   assign sep7_in = box_ff[6] | (|edge_sep);

   // stage 8: normal projection and radius; stage 9: compare
   always_comb begin
      p_in = '0;
      r_in = '0;
      for (int k = 0; k < 3; k++) begin
         p_in = p_in + (tbo_pkg::P_W'(ph_ff[k]) <<< tbo_pkg::NLO_W) + tbo_pkg::P_W'(pl_ff[k]);
         r_in = r_in + (tbo_pkg::R_W'(rh_ff[k]) << tbo_pkg::NLO_W) + tbo_pkg::R_W'(rl_ff[k]);
      end
   end

   assign prad   = $signed({1'b0, r_ff});
   assign nrad   = -prad;
   assign ovl_in = ~(sep8_ff | (p_ff > prad) | (p_ff < nrad));

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff     <= v1_in;
         v2_ff     <= v1_ff;
         e2_ff     <= e2_in;
         box_ff[2] <= box_in;
         v3_ff     <= v2_ff;
         e3_ff     <= e2_ff;
         ae3_ff    <= ae3_in;
         box_ff[3] <= box_ff[2];
         np_ff     <= np_in;
         v0_ff[4]  <= v3_ff[0];
         box_ff[4] <= box_ff[3];
         n5_ff     <= n_in;
         v0_ff[5]  <= v0_ff[4];
         box_ff[5] <= box_ff[4];
         n6_ff     <= n5_ff;
         an_ff     <= an_in;
         v0_ff[6]  <= v0_ff[5];
         box_ff[6] <= box_ff[5];
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         rl_ff     <= rl_in;
         rh_ff     <= rh_in;
         sep7_ff   <= sep7_in;
         p_ff      <= p_in;
         r_ff      <= r_in;
         sep8_ff   <= sep7_ff;
         ovl_ff    <= ovl_in;
      end
   end

   // edge cross box axis units, stages 4 to 6
   for (genvar i = 0; i < 3; i++) begin : g_edge
      for (genvar k = 0; k < 3; k++) begin : g_axis
         localparam int A = (k + 1) % 3;
         localparam int B = (k + 2) % 3;
         localparam int OPP = (i + 2) % 3;
         tbo_pkg::edge_opnd_type opnd;

         assign opnd.ea  = e3_ff[i][A];
         assign opnd.eb  = e3_ff[i][B];
         assign opnd.aea = ae3_ff[i][A];
         assign opnd.aeb = ae3_ff[i][B];
         assign opnd.va  = v3_ff[i][A];
         assign opnd.vb  = v3_ff[i][B];
         assign opnd.wa  = v3_ff[OPP][A];
         assign opnd.wb  = v3_ff[OPP][B];
         assign opnd.ha  = half_ff[A];
         assign opnd.hb  = half_ff[B];

         tbo_edge_axis u_axis (
            .clock (clock),
            .en    (en),
            .opnd  (opnd),
            .sep   (edge_sep[3*i+k])
         );
      end
   end

   assign rsp_bus.valid    = vld_ff[NSTG];
   assign rsp_bus.overlaps = ovl_ff;

   // checks
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> vld_ff[1])
      else $error("accepted request not in first stage");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.overlaps))
      else $error("stalled response changed");

endmodule
